>>> rtl/core/peqbq_pkg.sv
package peqbq_pkg;

   // stream and sample geometry
   localparam int NUM_STREAMS = 4;
   localparam int SAMPLE_BITS = 24;
   localparam int STREAM_BITS = 2;
   localparam int SLOTS       = 2 * NUM_STREAMS;
   localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // coefficient format, signed q5.22
   localparam int COEF_BITS = 28;
   localparam int COEF_FRAC = 22;

   // multiply-accumulate widths
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam int RND_BITS  = ACC_BITS - COEF_FRAC;

   // stream side-band: stream in the low bits, side above it
   localparam int USER_BITS = STREAM_BITS + 1;

   // control register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COEF_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NUM2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEN1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEN2 = 3'd4;

   // unity gain for num0 after reset
   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

   // filter coefficients
   typedef struct packed {
      logic signed [COEF_BITS-1:0] num0;
      logic signed [COEF_BITS-1:0] num1;
      logic signed [COEF_BITS-1:0] num2;
      logic signed [COEF_BITS-1:0] den1;
      logic signed [COEF_BITS-1:0] den2;
   } coef_type;

   // history of one slot
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [SAMPLE_BITS-1:0] x2;
      logic signed [SAMPLE_BITS-1:0] y1;
      logic signed [SAMPLE_BITS-1:0] y2;
   } hist_type;

   // history write request
   typedef struct packed {
      logic                          en;
      logic [SLOT_BITS-1:0]          slot;
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [SAMPLE_BITS-1:0] y;
   } hist_wr_type;

endpackage

>>> rtl/core/peqbq_coef_regs.sv
module peqbq_coef_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [peqbq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [peqbq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output peqbq_pkg::coef_type                  coef
);
   import peqbq_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_NUM0: coef_in.num0 = $signed(csr_wdata[COEF_BITS-1:0]);
            REG_NUM1: coef_in.num1 = $signed(csr_wdata[COEF_BITS-1:0]);
            REG_NUM2: coef_in.num2 = $signed(csr_wdata[COEF_BITS-1:0]);
            REG_DEN1: coef_in.den1 = $signed(csr_wdata[COEF_BITS-1:0]);
            REG_DEN2: coef_in.den2 = $signed(csr_wdata[COEF_BITS-1:0]);
            default:  coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.num0 <= COEF_ONE;
         coef_ff.num1 <= '0;
         coef_ff.num2 <= '0;
         coef_ff.den1 <= '0;
         coef_ff.den2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

>>> rtl/core/peqbq_hist.sv
module peqbq_hist (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [peqbq_pkg::SLOT_BITS-1:0] rd_slot,
   input  peqbq_pkg::hist_wr_type          wr,
   output peqbq_pkg::hist_type             hist
);
   import peqbq_pkg::*;

   logic signed [SAMPLE_BITS-1:0] past_in_one_ff  [SLOTS];
   logic signed [SAMPLE_BITS-1:0] past_in_two_ff  [SLOTS];
   logic signed [SAMPLE_BITS-1:0] past_out_one_ff [SLOTS];
   logic signed [SAMPLE_BITS-1:0] past_out_two_ff [SLOTS];

   // history of the slot being filtered
   always_comb begin
      hist.x1 = past_in_one_ff[rd_slot];
      hist.x2 = past_in_two_ff[rd_slot];
      hist.y1 = past_out_one_ff[rd_slot];
      hist.y2 = past_out_two_ff[rd_slot];
   end

   // shift in the new input and the saturated output
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            past_in_one_ff[i]  <= '0;
            past_in_two_ff[i]  <= '0;
            past_out_one_ff[i] <= '0;
            past_out_two_ff[i] <= '0;
         end
      end else if (wr.en) begin
         past_in_two_ff[wr.slot]  <= past_in_one_ff[wr.slot];
         past_in_one_ff[wr.slot]  <= wr.x;
         past_out_two_ff[wr.slot] <= past_out_one_ff[wr.slot];
         past_out_one_ff[wr.slot] <= wr.y;
      end
   end

endmodule

>>> rtl/core/peqbq_mac.sv
module peqbq_mac (
   input  logic signed [peqbq_pkg::SAMPLE_BITS-1:0] sample,
   input  peqbq_pkg::hist_type                      hist,
   input  peqbq_pkg::coef_type                      coef,
   output logic signed [peqbq_pkg::SAMPLE_BITS-1:0] result
);
   import peqbq_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (COEF_FRAC - 1);

   logic signed [PROD_BITS-1:0] prod_x0;
   logic signed [PROD_BITS-1:0] prod_x1;
   logic signed [PROD_BITS-1:0] prod_x2;
   logic signed [PROD_BITS-1:0] prod_y1;
   logic signed [PROD_BITS-1:0] prod_y2;
   logic signed [ACC_BITS-1:0]  acc;
   logic signed [ACC_BITS-1:0]  acc_rnd;
   logic signed [RND_BITS-1:0]  rnd;
   logic                        in_range;

   // five independent products
   assign prod_x0 = PROD_BITS'(sample)  * PROD_BITS'(coef.num0);
   assign prod_x1 = PROD_BITS'(hist.x1) * PROD_BITS'(coef.num1);
   assign prod_x2 = PROD_BITS'(hist.x2) * PROD_BITS'(coef.num2);
   assign prod_y1 = PROD_BITS'(hist.y1) * PROD_BITS'(coef.den1);
   assign prod_y2 = PROD_BITS'(hist.y2) * PROD_BITS'(coef.den2);

   // exact sum of the feedforward and feedback terms
   assign acc = ACC_BITS'(prod_x0) + ACC_BITS'(prod_x1) + ACC_BITS'(prod_x2)
              - ACC_BITS'(prod_y1) - ACC_BITS'(prod_y2);

   // round half up, then drop the coefficient fraction
   assign acc_rnd = acc + ROUND_HALF;
   assign rnd     = $signed(acc_rnd[ACC_BITS-1:COEF_FRAC]);

   // fits when all bits above the sample sign agree with it
   assign in_range = (&rnd[RND_BITS-1:SAMPLE_BITS-1]) | ~(|rnd[RND_BITS-1:SAMPLE_BITS-1]);

   always_comb begin
      if (in_range) begin
         result = rnd[SAMPLE_BITS-1:0];
      end else if (rnd[RND_BITS-1]) begin
         result = SAMPLE_MIN;
      end else begin
         result = SAMPLE_MAX;
      end
   end

endmodule

>>> rtl/core/peaking_eq_biquad_stereo.sv
// an accepted request moves from the input register into the result register when that frees up
// throughput: one request per cycle while the output is not stalled; the history of a slot is read,
// filtered and written back in the same cycle, so the multiply-accumulate path sets the clock
// reset: synchronous, active high; clears the valid flags, the history of every
// stream and side, and the coefficients to unity gain on num0
module peaking_eq_biquad_stereo (
   input  logic                                 clock,
   input  logic                                 reset,
   // control register write port
   input  logic                                 csr_wen,
   input  logic [peqbq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [peqbq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // input samples
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [peqbq_pkg::SAMPLE_BITS-1:0]    req_tdata,  // sample_in
   input  logic [peqbq_pkg::USER_BITS-1:0]      req_tuser,  // stream, side
   // filtered samples
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [peqbq_pkg::SAMPLE_BITS-1:0]    rsp_tdata,  // sample_out
   output logic [peqbq_pkg::USER_BITS-1:0]      rsp_tuser   // out_stream, out_side
);
   import peqbq_pkg::*;

   coef_type                      coef;
   hist_type                      hist;
   hist_wr_type                   hist_wr;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   logic                          s1_valid_ff;
   logic [STREAM_BITS-1:0]        s1_stream_ff;
   logic                          s1_side_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;

   logic                          out_valid_ff;
   logic [STREAM_BITS-1:0]        out_stream_ff;
   logic                          out_side_ff;
   logic [SAMPLE_BITS-1:0]        out_sample_ff;

   logic                          advance;
   logic                          accept;
   logic                          in_range;
   logic [SLOT_BITS-1:0]          slot;

   // handshake: the input register moves whenever the result register frees up
   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stream_ff <= req_tuser[STREAM_BITS-1:0];
         s1_side_ff   <= req_tuser[STREAM_BITS];
         s1_sample_ff <= $signed(req_tdata);
      end
   end

   // slot of the stream and side, streams past the end keep no history
   assign in_range = int'(s1_stream_ff) < NUM_STREAMS;
   assign slot     = SLOT_BITS'({s1_stream_ff, s1_side_ff});

   peqbq_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   peqbq_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (slot),
      .wr      (hist_wr),
      .hist    (hist)
   );

   peqbq_mac u_mac (
      .sample (s1_sample_ff),
      .hist   (hist),
      .coef   (coef),
      .result (mac_result)
   );

   // history update as the sample leaves the input register
   always_comb begin
      hist_wr.en   = s1_valid_ff & advance & in_range;
      hist_wr.slot = slot;
      hist_wr.x    = s1_sample_ff;
      hist_wr.y    = mac_result;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & s1_valid_ff) begin
         out_stream_ff <= s1_stream_ff;
         out_side_ff   <= s1_side_ff;
         out_sample_ff <= in_range ? mac_result : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = {out_side_ff, out_stream_ff};

endmodule

>>> rtl/core/peqbq_checker.sv
module peqbq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_wen,
   input logic [peqbq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [peqbq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [peqbq_pkg::SAMPLE_BITS-1:0]    req_tdata,
   input logic [peqbq_pkg::USER_BITS-1:0]      req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [peqbq_pkg::SAMPLE_BITS-1:0]    rsp_tdata,
   input logic [peqbq_pkg::USER_BITS-1:0]      rsp_tuser
);
   import peqbq_pkg::*;

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an accepted request reaches the output when the sink keeps taking results
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted request did not reach the output");

   // an empty output never blocks new requests
   a_no_bubble: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output is empty");

endmodule

bind peaking_eq_biquad_stereo peqbq_checker u_peqbq_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import peqbq_pkg::*;

   localparam int LATENCY        = 2;
   localparam int IDLE_PCT       = 38;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 160;
   localparam int PHASES         = 7;

   localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam longint LIMIT_HI = (longint'(1) << (SAMPLE_BITS-1)) - 1;
   localparam longint LIMIT_LO = -LIMIT_HI - 1;

   // one filtered sample as it should leave the block
   typedef struct {
      logic [STREAM_BITS-1:0]        stream_no;
      logic                          side;
      logic signed [SAMPLE_BITS-1:0] sample;
   } filtered_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [SAMPLE_BITS-1:0]    req_tdata = '0;   // sample_in
   logic [USER_BITS-1:0]      req_tuser = '0;   // stream, side
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_tdata;        // sample_out
   logic [USER_BITS-1:0]      rsp_tuser;        // out_stream, out_side

   // shared test controls
   logic steady      = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;
   int   error_count = 0;
   int   next_slot   = 0;

   // predictor state
   coef_type     coefs;
   hist_type     history [SLOTS];
   filtered_type filtered_q [$];

   peaking_eq_biquad_stereo u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // direct form i step for one slot, with history update
   function automatic logic signed [SAMPLE_BITS-1:0] biquad_step(
      input logic [SLOT_BITS-1:0] slot, input logic signed [SAMPLE_BITS-1:0] x);
      longint acc;
      longint rounded;
      logic signed [SAMPLE_BITS-1:0] y;
      acc = longint'($signed(coefs.num0)) * longint'(x)
          + longint'($signed(coefs.num1)) * longint'($signed(history[slot].x1))
          + longint'($signed(coefs.num2)) * longint'($signed(history[slot].x2))
          - longint'($signed(coefs.den1)) * longint'($signed(history[slot].y1))
          - longint'($signed(coefs.den2)) * longint'($signed(history[slot].y2));
      // round half up, then clamp to the sample range
      rounded = (acc + (longint'(1) <<< (COEF_FRAC-1))) >>> COEF_FRAC;
      if (rounded > LIMIT_HI)
         y = SMP_MAX;
      else if (rounded < LIMIT_LO)
         y = SMP_MIN;
      else
         y = SAMPLE_BITS'(rounded);
      history[slot].x2 = history[slot].x1;
      history[slot].x1 = x;
      history[slot].y2 = history[slot].y1;
      history[slot].y1 = y;
      return y;
   endfunction

   // random sample, weighted toward extremes and small values
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // stable peaking filters designed offline
   function automatic coef_type eq_preset(input int which);
      coef_type c;
      case (which)
         0: c = '{num0: 28'sd4394082, num1: -28'sd7906288, num2: 28'sd3593075,
                  den1: -28'sd7906288, den2: 28'sd3792809};
         1: c = '{num0: 28'sd2422001, num1: -28'sd1525256, num2: 28'sd1233043,
                  den1: -28'sd1525256, den2: -28'sd539304};
         default: c = '{num0: 28'sd4216584, num1: -28'sd8372812, num2: 28'sd4157079,
                        den1: -28'sd8372812, den2: 28'sd4179356};
      endcase
      return c;
   endfunction

   // stop offering, wait for every filtered sample and let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] value);
      drain_results();
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         REG_NUM0: coefs.num0 = value;
         REG_NUM1: coefs.num1 = value;
         REG_NUM2: coefs.num2 = value;
         REG_DEN1: coefs.den1 = value;
         REG_DEN2: coefs.den2 = value;
         default: ;
      endcase
   endtask

   task automatic write_coef_set(input coef_type c);
      write_coef(REG_NUM0, c.num0);
      write_coef(REG_NUM1, c.num1);
      write_coef(REG_NUM2, c.num2);
      write_coef(REG_DEN1, c.den1);
      write_coef(REG_DEN2, c.den2);
   endtask

   // offer one request, hold it until taken, then predict its output
   task automatic send_sample(input logic [STREAM_BITS-1:0] stream_no, input logic side,
                              input logic signed [SAMPLE_BITS-1:0] x);
      filtered_type f;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            req_tdata  <= SAMPLE_BITS'($urandom);
            req_tuser  <= USER_BITS'($urandom);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tuser  <= {side, stream_no};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      f.stream_no = stream_no;
      f.side      = side;
      f.sample    = biquad_step({stream_no, side}, x);
      filtered_q.push_back(f);
   endtask

   // mostly interleaved slot order, sometimes a random slot
   task automatic send_random_sample();
      logic [SLOT_BITS-1:0] slot;
      if ($urandom_range(0, 3) != 0) begin
         slot = SLOT_BITS'(next_slot);
         next_slot = (next_slot + 1) % SLOTS;
      end else begin
         slot = SLOT_BITS'($urandom_range(0, SLOTS-1));
      end
      send_sample(slot[SLOT_BITS-1:1], slot[0], pick_sample());
   endtask

   // reset coefficients pass samples through on every slot
   task automatic test_unity_passthrough();
      send_sample(2'd0, 1'b0, SMP_MAX);
      send_sample(2'd0, 1'b1, SMP_MIN);
      send_sample(2'd1, 1'b0, '0);
      send_sample(2'd1, 1'b1, -24'sd1);
      send_sample(2'd2, 1'b0, 24'sd1);
      send_sample(2'd2, 1'b1, 24'sh555555);
      send_sample(2'd3, 1'b0, 24'shAAAAAA);
      send_sample(2'd3, 1'b1, 24'sh123456);
   endtask

   // smallest num0 puts the half-way points right at the rounding step
   task automatic test_rounding();
      write_coef(REG_NUM0, 28'sd1);
      send_sample(2'd1, 1'b0, 24'sd2097152);
      send_sample(2'd1, 1'b0, -24'sd2097152);
      send_sample(2'd1, 1'b0, -24'sd2097153);
      send_sample(2'd1, 1'b0, 24'sd2097151);
   endtask

   // largest gains of both signs drive the output into both rails
   task automatic test_coef_extremes();
      write_coef(REG_NUM0, COEF_MAX);
      send_sample(2'd2, 1'b0, SMP_MAX);
      send_sample(2'd2, 1'b0, SMP_MIN);
      write_coef(REG_NUM0, COEF_MIN);
      send_sample(2'd2, 1'b1, SMP_MAX);
      send_sample(2'd2, 1'b1, SMP_MIN);
   endtask

   // clamped output, not the raw sum, must come back through the feedback
   task automatic test_feedback_saturation();
      write_coef_set('{num0: COEF_ONE <<< 1, num1: '0, num2: '0, den1: -COEF_ONE, den2: '0});
      send_sample(2'd3, 1'b1, SMP_MAX);
      send_sample(2'd3, 1'b1, SMP_MAX);
      send_sample(2'd3, 1'b1, '0);
      send_sample(2'd3, 1'b1, SMP_MIN);
      write_coef_set('{num0: COEF_ONE, num1: COEF_MAX, num2: COEF_MIN,
                       den1: COEF_MIN, den2: COEF_MAX});
      send_sample(2'd0, 1'b0, 24'sd1000);
      send_sample(2'd0, 1'b0, SMP_MIN);
      send_sample(2'd0, 1'b0, SMP_MAX);
   endtask

   // several coefficient settings, each with a burst of random samples
   task automatic test_random_filters();
      coef_type c;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0: c = eq_preset($urandom_range(0, 2));
            1: begin
               c.num0 = COEF_BITS'(int'($urandom_range(0, 2 << COEF_FRAC)) - (1 << COEF_FRAC));
               c.num1 = COEF_BITS'(int'($urandom_range(0, 2 << COEF_FRAC)) - (1 << COEF_FRAC));
               c.num2 = COEF_BITS'(int'($urandom_range(0, 2 << COEF_FRAC)) - (1 << COEF_FRAC));
               c.den1 = COEF_BITS'(int'($urandom_range(0, 2 << COEF_FRAC)) - (1 << COEF_FRAC));
               c.den2 = COEF_BITS'(int'($urandom_range(0, 2 << COEF_FRAC)) - (1 << COEF_FRAC));
            end
            default: begin
               c.num0 = COEF_BITS'($urandom);
               c.num1 = COEF_BITS'($urandom);
               c.num2 = COEF_BITS'($urandom);
               c.den1 = COEF_BITS'($urandom);
               c.den2 = COEF_BITS'($urandom);
            end
         endcase
         write_coef_set(c);
         // one phase runs at full rate on both sides
         if (phase == 3) steady <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_sample();
         if (phase == 3) steady <= 1'b0;
      end
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      write_coef_set(eq_preset(0));
      steady      <= 1'b1;
      hold_toggle <= ~hold_toggle;
      for (int n = 0; n < 48; n++) send_random_sample();
      steady <= 1'b0;
   endtask

   // output ready: random idling, long holds on request, no random idling when steady
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each filtered sample with the oldest prediction
   always @(posedge clock) begin : check_output
      filtered_type f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            $error("unexpected output: stream %0d side %0d sample %0d",
                   rsp_tuser[STREAM_BITS-1:0], rsp_tuser[STREAM_BITS], $signed(rsp_tdata));
            error_count = error_count + 1;
         end else begin
            f = filtered_q.pop_front();
            if (rsp_tuser[STREAM_BITS-1:0] !== f.stream_no) begin
               $error("out_stream: expected %0d, actual %0d",
                      f.stream_no, rsp_tuser[STREAM_BITS-1:0]);
               error_count = error_count + 1;
            end
            if (rsp_tuser[STREAM_BITS] !== f.side) begin
               $error("out_side: expected %0d, actual %0d", f.side, rsp_tuser[STREAM_BITS]);
               error_count = error_count + 1;
            end
            if (rsp_tdata !== f.sample) begin
               $error("sample_out: expected %0d, actual %0d", f.sample, $signed(rsp_tdata));
               error_count = error_count + 1;
            end
         end
      end
   end

   // end the run if no handshake happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet = quiet + 1;
      end
      $display("peaking_eq_biquad_stereo test failed");
      $finish;
   end

   initial begin
      coefs = '{num0: COEF_ONE, num1: '0, num2: '0, den1: '0, den2: '0};
      for (int i = 0; i < SLOTS; i++) history[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unity_passthrough();
      test_rounding();
      test_coef_extremes();
      test_feedback_saturation();
      test_random_filters();
      test_output_backpressure();

      drain_results();
      if (error_count == 0)
         $display("peaking_eq_biquad_stereo test passed");
      else
         $display("peaking_eq_biquad_stereo test failed");
      $finish;
   end

endmodule
